@@ design/opdec_pkg.sv @@
// Package for the opcode decoder: instruction class codes, operand codes
// and the decoded result record. No dependencies.

package opdec_pkg;

	localparam int OpcodeWidth = 8;
	localparam int ClassWidth  = 6;
	localparam int OperWidth   = 4;

	typedef enum logic [ClassWidth-1:0] {
		CL_NOP     = 6'd0,
		CL_ERR     = 6'd1,
		CL_ADD     = 6'd2,
		CL_ADDHL16 = 6'd3,
		CL_ADC     = 6'd4,
		CL_SUB     = 6'd5,
		CL_SBC     = 6'd6,
		CL_AND     = 6'd7,
		CL_OR      = 6'd8,
		CL_XOR     = 6'd9,
		CL_CP      = 6'd10,
		CL_INC     = 6'd11,
		CL_INC16   = 6'd12,
		CL_DEC     = 6'd13,
		CL_DEC16   = 6'd14,
		CL_CCF     = 6'd15,
		CL_SCF     = 6'd16,
		CL_RRA     = 6'd17,
		CL_RLA     = 6'd18,
		CL_RRCA    = 6'd19,
		CL_RLCA    = 6'd20,
		CL_CPL     = 6'd21,
		CL_BIT     = 6'd22,
		CL_RES     = 6'd23,
		CL_SET     = 6'd24,
		CL_SRL     = 6'd25,
		CL_RR      = 6'd26,
		CL_RL      = 6'd27,
		CL_RRC     = 6'd28,
		CL_RLC     = 6'd29,
		CL_SRA     = 6'd30,
		CL_SLA     = 6'd31,
		CL_SWAP    = 6'd32,
		CL_JR      = 6'd33,
		CL_JPI     = 6'd34,
		CL_LOAD    = 6'd35,
		CL_LOAD16  = 6'd36
	} instr_class_t;

	typedef logic [OperWidth-1:0] oper_t;

	// 8-bit register operands.
	localparam oper_t OP_HLP = 4'd6;
	localparam oper_t OP_A   = 4'd7;
	localparam oper_t OP_IMM = 4'd8;

	// Load targets beyond the registers.
	localparam oper_t DST_BC_IND  = 4'd8;
	localparam oper_t DST_DE_IND  = 4'd9;
	localparam oper_t DST_A16_IND = 4'd10;
	localparam oper_t DST_C_IND   = 4'd11;
	localparam oper_t DST_HLD     = 4'd12;
	localparam oper_t DST_HLI     = 4'd13;
	localparam oper_t DST_A8_IND  = 4'd14;

	// Load sources beyond the registers.
	localparam oper_t SRC_IMM8    = 4'd8;
	localparam oper_t SRC_BC_IND  = 4'd9;
	localparam oper_t SRC_DE_IND  = 4'd10;
	localparam oper_t SRC_A16_IND = 4'd11;
	localparam oper_t SRC_C_IND   = 4'd12;
	localparam oper_t SRC_HLD     = 4'd13;
	localparam oper_t SRC_HLI     = 4'd14;
	localparam oper_t SRC_A8_IND  = 4'd15;

	// 16-bit load operands.
	localparam oper_t PAIR_HL      = 4'd2;
	localparam oper_t PAIR_SP      = 4'd3;
	localparam oper_t DST16_A16    = 4'd4;
	localparam oper_t SRC16_HL     = 4'd1;
	localparam oper_t SRC16_SP_OFS = 4'd2;
	localparam oper_t SRC16_SP     = 4'd3;
	localparam oper_t OPER_NONE    = 4'd0;

	typedef struct packed {
		instr_class_t cls;
		oper_t        first;
		oper_t        second;
	} decode_t;

endpackage

@@ design/cpu_opcode_decoder.sv @@
// Opcode decoder for an 8-bit CPU core, plain and prefix-0xCB tables.
// Depends on opdec_pkg for class codes, operand codes and the result record.
//
// Usage:
// An item on the input channel is one opcode byte plus a flag that marks it
// as following the 0xCB prefix. Each item gives exactly one result item:
// the instruction class, two operand codes and an error flag for opcodes
// outside the tables. The item is captured in an input register, decoded by
// a single layer of table logic and held in a result register. One item is
// accepted per cycle, sustained, as long as the receiver takes results.
// When the receiver stalls, the result register holds its item and the
// input register fills behind it; ready falls only when both are full,
// and rises again in the cycle the receiver takes a result.
// Reset clears both valid flags; no result is shown until an item arrives.

module cpu_opcode_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [opdec_pkg::OpcodeWidth-1:0]   opcode,
	input  logic                                prefixed,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [opdec_pkg::ClassWidth-1:0]    instr_class,
	output logic [opdec_pkg::OperWidth-1:0]     operand_first,
	output logic [opdec_pkg::OperWidth-1:0]     operand_second,
	output logic                                is_error
);
	import opdec_pkg::*;

	logic                   valid_s1;
	logic [OpcodeWidth-1:0] opcode_s1;
	logic                   prefixed_s1;
	logic                   valid_s2;
	decode_t                result_s2;
	decode_t                dec;
	logic                   adv_s2;
	logic                   adv_s1;
	logic [2:0]             mid;
	logic [2:0]             reg_lo;
	oper_t                  pair;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			opcode_s1   <= opcode;
			prefixed_s1 <= prefixed;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= dec;
		end
	end

	assign mid    = opcode_s1[5:3];
	assign reg_lo = opcode_s1[2:0];
	assign pair   = {2'b00, opcode_s1[5:4]};

	always_comb begin
		dec = '{cls: CL_ERR, first: OPER_NONE, second: OPER_NONE};
		if (prefixed_s1) begin
			if (opcode_s1[7:6] == 2'b00) begin
				dec.first = {1'b0, reg_lo};
				unique case (mid)
					3'd0: dec.cls = CL_RLC;
					3'd1: dec.cls = CL_RRC;
					3'd2: dec.cls = CL_RL;
					3'd3: dec.cls = CL_RR;
					3'd4: dec.cls = CL_SLA;
					3'd5: dec.cls = CL_SRA;
					3'd6: dec.cls = CL_SWAP;
					default: dec.cls = CL_SRL;
				endcase
			end else if (mid == 3'd0) begin
				// Only the bit-0 rows of BIT, RES and SET are in the table.
				dec.first = {1'b0, reg_lo};
				unique case (opcode_s1[7:6])
					2'b01: dec.cls = CL_BIT;
					2'b10: dec.cls = CL_RES;
					default: dec.cls = CL_SET;
				endcase
			end
		end else if (opcode_s1[7:6] == 2'b01) begin
			// The register-to-register load block, with HALT left out.
			if (mid != 3'd6 || reg_lo != 3'd6) begin
				dec = '{cls: CL_LOAD, first: {1'b0, mid}, second: {1'b0, reg_lo}};
			end
		end else if (opcode_s1[7:6] == 2'b10) begin
			dec.first = {1'b0, reg_lo};
			unique case (mid)
				3'd0: dec.cls = CL_ADD;
				3'd1: dec.cls = CL_ADC;
				3'd2: dec.cls = CL_SUB;
				3'd3: dec.cls = CL_SBC;
				3'd4: dec.cls = CL_AND;
				3'd5: dec.cls = CL_XOR;
				3'd6: dec.cls = CL_OR;
				default: dec.cls = CL_CP;
			endcase
		end else if (opcode_s1[7:6] == 2'b00 && reg_lo == 3'd4) begin
			dec = '{cls: CL_INC, first: {1'b0, mid}, second: OPER_NONE};
		end else if (opcode_s1[7:6] == 2'b00 && reg_lo == 3'd5) begin
			dec = '{cls: CL_DEC, first: {1'b0, mid}, second: OPER_NONE};
		end else if (opcode_s1[7:6] == 2'b00 && opcode_s1[3:0] == 4'h3) begin
			dec = '{cls: CL_INC16, first: pair, second: OPER_NONE};
		end else if (opcode_s1[7:6] == 2'b00 && opcode_s1[3:0] == 4'hB) begin
			dec = '{cls: CL_DEC16, first: pair, second: OPER_NONE};
		end else if (opcode_s1[7:6] == 2'b00 && opcode_s1[3:0] == 4'h9) begin
			dec = '{cls: CL_ADDHL16, first: pair, second: OPER_NONE};
		end else if (opcode_s1[7:6] == 2'b00 && opcode_s1[3:0] == 4'h1) begin
			dec = '{cls: CL_LOAD16, first: pair, second: OPER_NONE};
		end else begin
			unique case (opcode_s1) inside
				8'h00: dec.cls = CL_NOP;
				8'hC6: dec = '{cls: CL_ADD, first: OP_IMM, second: OPER_NONE};
				8'hCE: dec = '{cls: CL_ADC, first: OP_IMM, second: OPER_NONE};
				8'hD6: dec = '{cls: CL_SUB, first: OP_IMM, second: OPER_NONE};
				8'hE6: dec = '{cls: CL_AND, first: OP_IMM, second: OPER_NONE};
				8'hEE: dec = '{cls: CL_XOR, first: OP_IMM, second: OPER_NONE};
				8'hF6: dec = '{cls: CL_OR, first: OP_IMM, second: OPER_NONE};
				8'hFE: dec = '{cls: CL_CP, first: OP_IMM, second: OPER_NONE};
				8'h2F: dec.cls = CL_CPL;
				8'h3F: dec.cls = CL_CCF;
				8'h37: dec.cls = CL_SCF;
				8'h07: dec.cls = CL_RLCA;
				8'h17: dec.cls = CL_RLA;
				8'h0F: dec.cls = CL_RRCA;
				8'h1F: dec.cls = CL_RRA;
				8'h20, 8'h28, 8'h30, 8'h38:
					dec = '{cls: CL_JR, first: {2'b00, mid[1:0]}, second: OPER_NONE};
				8'hE9: dec.cls = CL_JPI;
				8'h36: dec = '{cls: CL_LOAD, first: OP_HLP, second: SRC_IMM8};
				8'h0A: dec = '{cls: CL_LOAD, first: OP_A, second: SRC_BC_IND};
				8'h1A: dec = '{cls: CL_LOAD, first: OP_A, second: SRC_DE_IND};
				8'hFA: dec = '{cls: CL_LOAD, first: OP_A, second: SRC_A16_IND};
				8'h3E: dec = '{cls: CL_LOAD, first: OP_A, second: SRC_IMM8};
				8'h02: dec = '{cls: CL_LOAD, first: DST_BC_IND, second: OP_A};
				8'h12: dec = '{cls: CL_LOAD, first: DST_DE_IND, second: OP_A};
				8'hEA: dec = '{cls: CL_LOAD, first: DST_A16_IND, second: OP_A};
				8'hF2: dec = '{cls: CL_LOAD, first: OP_A, second: SRC_C_IND};
				8'hE2: dec = '{cls: CL_LOAD, first: DST_C_IND, second: OP_A};
				8'h3A: dec = '{cls: CL_LOAD, first: OP_A, second: SRC_HLD};
				8'h32: dec = '{cls: CL_LOAD, first: DST_HLD, second: OP_A};
				8'h2A: dec = '{cls: CL_LOAD, first: OP_A, second: SRC_HLI};
				8'h22: dec = '{cls: CL_LOAD, first: DST_HLI, second: OP_A};
				8'hE0: dec = '{cls: CL_LOAD, first: DST_A8_IND, second: OP_A};
				8'hF0: dec = '{cls: CL_LOAD, first: OP_A, second: SRC_A8_IND};
				8'hF9: dec = '{cls: CL_LOAD16, first: PAIR_SP, second: SRC16_HL};
				8'hF8: dec = '{cls: CL_LOAD16, first: PAIR_HL, second: SRC16_SP_OFS};
				8'h08: dec = '{cls: CL_LOAD16, first: DST16_A16, second: SRC16_SP};
				default: dec = '{cls: CL_ERR, first: OPER_NONE, second: OPER_NONE};
			endcase
		end
	end

	assign out_valid      = valid_s2;
	assign instr_class    = result_s2.cls;
	assign operand_first  = result_s2.first;
	assign operand_second = result_s2.second;
	assign is_error       = (result_s2.cls == CL_ERR);

endmodule

@@ tb/decode_checker.sv @@
`timescale 1ns / 100ps
// Checker for cpu_opcode_decoder: watches both channels, predicts each decode
// and compares results in order. Depends on opdec_pkg for class and operand codes.

module decode_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [opdec_pkg::OpcodeWidth-1:0]   opcode,
	input  logic                                prefixed,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [opdec_pkg::ClassWidth-1:0]    instr_class,
	input  logic [opdec_pkg::OperWidth-1:0]     operand_first,
	input  logic [opdec_pkg::OperWidth-1:0]     operand_second,
	input  logic                                is_error,
	output int                                  mismatches,
	output int                                  pending,
	output int                                  results_checked,
	output logic [36:0]                         class_hits
);
	import opdec_pkg::*;

	// Plain-table opcodes that are decoded one by one.
	localparam logic [7:0] OPC_NOP = 8'h00, OPC_ADD_IMM = 8'hC6, OPC_ADC_IMM = 8'hCE,
		OPC_SUB_IMM = 8'hD6, OPC_AND_IMM = 8'hE6, OPC_XOR_IMM = 8'hEE,
		OPC_OR_IMM = 8'hF6, OPC_CP_IMM = 8'hFE, OPC_CPL = 8'h2F, OPC_CCF = 8'h3F,
		OPC_SCF = 8'h37, OPC_RLCA = 8'h07, OPC_RLA = 8'h17, OPC_RRCA = 8'h0F,
		OPC_RRA = 8'h1F, OPC_JR_NZ = 8'h20, OPC_JR_Z = 8'h28, OPC_JR_NC = 8'h30,
		OPC_JR_C = 8'h38, OPC_JP_HL = 8'hE9, OPC_HALT = 8'h76,
		OPC_LD_HLP_IMM = 8'h36, OPC_LD_A_BCI = 8'h0A, OPC_LD_A_DEI = 8'h1A,
		OPC_LD_A_A16 = 8'hFA, OPC_LD_A_IMM = 8'h3E, OPC_LD_BCI_A = 8'h02,
		OPC_LD_DEI_A = 8'h12, OPC_LD_A16_A = 8'hEA, OPC_LD_A_CI = 8'hF2,
		OPC_LD_CI_A = 8'hE2, OPC_LD_A_HLD = 8'h3A, OPC_LD_HLD_A = 8'h32,
		OPC_LD_A_HLI = 8'h2A, OPC_LD_HLI_A = 8'h22, OPC_LDH_A8_A = 8'hE0,
		OPC_LDH_A_A8 = 8'hF0, OPC_LD_SP_HL = 8'hF9, OPC_LD_HL_SPOFS = 8'hF8,
		OPC_LD_A16_SP = 8'h08;

	typedef struct packed {
		logic         pfx;
		logic [7:0]   op;
		instr_class_t cls;
		oper_t        first;
		oper_t        second;
		logic         err;
	} decode_rec_t;

	decode_rec_t pending_decodes[$];
	decode_rec_t oldest;

	function automatic decode_rec_t make_rec(instr_class_t c, oper_t a, oper_t b);
		decode_rec_t r;
		r.pfx    = 1'b0;
		r.op     = '0;
		r.cls    = c;
		r.first  = a;
		r.second = b;
		r.err    = (c == CL_ERR);
		return r;
	endfunction

	function automatic decode_rec_t predict_decode(logic [7:0] op, logic pfx);
		decode_rec_t r;
		oper_t       reg_sel;
		oper_t       mid;
		oper_t       pair;
		logic        done;
		reg_sel = {1'b0, op[2:0]};
		mid     = {1'b0, op[5:3]};
		pair    = {2'b0, op[5:4]};
		done    = 1'b0;
		r       = make_rec(CL_ERR, OPER_NONE, OPER_NONE);
		if (pfx) begin
			if (op[7:6] == 2'b00) begin
				case (op[5:3])
					3'd0: r = make_rec(CL_RLC, reg_sel, OPER_NONE);
					3'd1: r = make_rec(CL_RRC, reg_sel, OPER_NONE);
					3'd2: r = make_rec(CL_RL, reg_sel, OPER_NONE);
					3'd3: r = make_rec(CL_RR, reg_sel, OPER_NONE);
					3'd4: r = make_rec(CL_SLA, reg_sel, OPER_NONE);
					3'd5: r = make_rec(CL_SRA, reg_sel, OPER_NONE);
					3'd6: r = make_rec(CL_SWAP, reg_sel, OPER_NONE);
					default: r = make_rec(CL_SRL, reg_sel, OPER_NONE);
				endcase
			end else if (op[5:3] == 3'd0) begin
				// Only bit position zero of BIT, RES and SET is in the table.
				case (op[7:6])
					2'b01: r = make_rec(CL_BIT, reg_sel, OPER_NONE);
					2'b10: r = make_rec(CL_RES, reg_sel, OPER_NONE);
					default: r = make_rec(CL_SET, reg_sel, OPER_NONE);
				endcase
			end
		end else if (op[7:6] == 2'b01) begin
			if (op != OPC_HALT)
				r = make_rec(CL_LOAD, mid, reg_sel);
		end else if (op[7:6] == 2'b10) begin
			case (op[5:3])
				3'd0: r = make_rec(CL_ADD, reg_sel, OPER_NONE);
				3'd1: r = make_rec(CL_ADC, reg_sel, OPER_NONE);
				3'd2: r = make_rec(CL_SUB, reg_sel, OPER_NONE);
				3'd3: r = make_rec(CL_SBC, reg_sel, OPER_NONE);
				3'd4: r = make_rec(CL_AND, reg_sel, OPER_NONE);
				3'd5: r = make_rec(CL_XOR, reg_sel, OPER_NONE);
				3'd6: r = make_rec(CL_OR, reg_sel, OPER_NONE);
				default: r = make_rec(CL_CP, reg_sel, OPER_NONE);
			endcase
		end else begin
			if (op[7:6] == 2'b00) begin
				done = 1'b1;
				if (op[2:0] == 3'd4)
					r = make_rec(CL_INC, mid, OPER_NONE);
				else if (op[2:0] == 3'd5)
					r = make_rec(CL_DEC, mid, OPER_NONE);
				else if (op[3:0] == 4'h3)
					r = make_rec(CL_INC16, pair, OPER_NONE);
				else if (op[3:0] == 4'hB)
					r = make_rec(CL_DEC16, pair, OPER_NONE);
				else if (op[3:0] == 4'h9)
					r = make_rec(CL_ADDHL16, pair, OPER_NONE);
				else if (op[3:0] == 4'h1)
					r = make_rec(CL_LOAD16, pair, OPER_NONE);
				else
					done = 1'b0;
			end
			if (!done) begin
				case (op)
					OPC_NOP:         r = make_rec(CL_NOP, OPER_NONE, OPER_NONE);
					OPC_ADD_IMM:     r = make_rec(CL_ADD, OP_IMM, OPER_NONE);
					OPC_ADC_IMM:     r = make_rec(CL_ADC, OP_IMM, OPER_NONE);
					OPC_SUB_IMM:     r = make_rec(CL_SUB, OP_IMM, OPER_NONE);
					OPC_AND_IMM:     r = make_rec(CL_AND, OP_IMM, OPER_NONE);
					OPC_XOR_IMM:     r = make_rec(CL_XOR, OP_IMM, OPER_NONE);
					OPC_OR_IMM:      r = make_rec(CL_OR, OP_IMM, OPER_NONE);
					OPC_CP_IMM:      r = make_rec(CL_CP, OP_IMM, OPER_NONE);
					OPC_CPL:         r = make_rec(CL_CPL, OPER_NONE, OPER_NONE);
					OPC_CCF:         r = make_rec(CL_CCF, OPER_NONE, OPER_NONE);
					OPC_SCF:         r = make_rec(CL_SCF, OPER_NONE, OPER_NONE);
					OPC_RLCA:        r = make_rec(CL_RLCA, OPER_NONE, OPER_NONE);
					OPC_RLA:         r = make_rec(CL_RLA, OPER_NONE, OPER_NONE);
					OPC_RRCA:        r = make_rec(CL_RRCA, OPER_NONE, OPER_NONE);
					OPC_RRA:         r = make_rec(CL_RRA, OPER_NONE, OPER_NONE);
					OPC_JR_NZ, OPC_JR_Z, OPC_JR_NC, OPC_JR_C:
						r = make_rec(CL_JR, {2'b0, op[4:3]}, OPER_NONE);
					OPC_JP_HL:       r = make_rec(CL_JPI, OPER_NONE, OPER_NONE);
					OPC_LD_HLP_IMM:  r = make_rec(CL_LOAD, OP_HLP, SRC_IMM8);
					OPC_LD_A_BCI:    r = make_rec(CL_LOAD, OP_A, SRC_BC_IND);
					OPC_LD_A_DEI:    r = make_rec(CL_LOAD, OP_A, SRC_DE_IND);
					OPC_LD_A_A16:    r = make_rec(CL_LOAD, OP_A, SRC_A16_IND);
					OPC_LD_A_IMM:    r = make_rec(CL_LOAD, OP_A, SRC_IMM8);
					OPC_LD_BCI_A:    r = make_rec(CL_LOAD, DST_BC_IND, OP_A);
					OPC_LD_DEI_A:    r = make_rec(CL_LOAD, DST_DE_IND, OP_A);
					OPC_LD_A16_A:    r = make_rec(CL_LOAD, DST_A16_IND, OP_A);
					OPC_LD_A_CI:     r = make_rec(CL_LOAD, OP_A, SRC_C_IND);
					OPC_LD_CI_A:     r = make_rec(CL_LOAD, DST_C_IND, OP_A);
					OPC_LD_A_HLD:    r = make_rec(CL_LOAD, OP_A, SRC_HLD);
					OPC_LD_HLD_A:    r = make_rec(CL_LOAD, DST_HLD, OP_A);
					OPC_LD_A_HLI:    r = make_rec(CL_LOAD, OP_A, SRC_HLI);
					OPC_LD_HLI_A:    r = make_rec(CL_LOAD, DST_HLI, OP_A);
					OPC_LDH_A8_A:    r = make_rec(CL_LOAD, DST_A8_IND, OP_A);
					OPC_LDH_A_A8:    r = make_rec(CL_LOAD, OP_A, SRC_A8_IND);
					OPC_LD_SP_HL:    r = make_rec(CL_LOAD16, PAIR_SP, SRC16_HL);
					OPC_LD_HL_SPOFS: r = make_rec(CL_LOAD16, PAIR_HL, SRC16_SP_OFS);
					OPC_LD_A16_SP:   r = make_rec(CL_LOAD16, DST16_A16, SRC16_SP);
					default:         r = make_rec(CL_ERR, OPER_NONE, OPER_NONE);
				endcase
			end
		end
		r.pfx = pfx;
		r.op  = op;
		return r;
	endfunction

	task automatic compare_field(string field, logic [7:0] want, logic [7:0] got,
		decode_rec_t src);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s wrong for %s opcode %02h: expected %0d, got %0d",
				$time, field, src.pfx ? "prefixed" : "plain", src.op, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_decodes.delete();
			pending         = 0;
			mismatches      = 0;
			results_checked = 0;
			class_hits      = '0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_decodes.size() == 0) begin
					mismatches++;
					$display("%0t: result with no item pending: expected none, got class %0d",
						$time, instr_class);
				end else begin
					oldest = pending_decodes.pop_front();
					compare_field("instr_class", 8'(oldest.cls), 8'(instr_class), oldest);
					compare_field("operand_first", 8'(oldest.first), 8'(operand_first), oldest);
					compare_field("operand_second", 8'(oldest.second), 8'(operand_second),
						oldest);
					compare_field("is_error", 8'(oldest.err), 8'(is_error), oldest);
					results_checked++;
					class_hits[int'(oldest.cls)] = 1'b1;
				end
			end
			if (in_valid && in_ready)
				pending_decodes.push_back(predict_decode(opcode, prefixed));
			pending = pending_decodes.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Top of the cpu_opcode_decoder testbench: clock, reset, opcode stimulus with
// random flow control, and the verdict. Depends on decode_checker and opdec_pkg.

module tb;
	import opdec_pkg::*;

	localparam int RandomItems = 1426;
	localparam int CalmTail    = 150;
	localparam int SegmentLen  = 150;
	localparam int TailCycles  = 8;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [OpcodeWidth-1:0] opcode;
	logic                   prefixed;
	logic                   out_valid;
	logic                   out_ready;
	logic [ClassWidth-1:0]  instr_class;
	logic [OperWidth-1:0]   operand_first;
	logic [OperWidth-1:0]   operand_second;
	logic                   is_error;

	int          mismatches;
	int          pending;
	int          results_checked;
	logic [36:0] class_hits;
	int          idle_pct;
	int          items_sent;

	cpu_opcode_decoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.prefixed       (prefixed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.instr_class    (instr_class),
		.operand_first  (operand_first),
		.operand_second (operand_second),
		.is_error       (is_error)
	);

	decode_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.prefixed        (prefixed),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.instr_class     (instr_class),
		.operand_first   (operand_first),
		.operand_second  (operand_second),
		.is_error        (is_error),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked),
		.class_hits      (class_hits)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Timed out with %0d results still pending.", pending);
		$display("** cpu_opcode_decoder: FAILED **");
		$finish;
	end

	// Result side: stalls in short random bursts at the current idle rate.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && $urandom_range(0, 99) < idle_pct)
				hold_left = $urandom_range(1, 5);
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_opcode(logic [7:0] op, logic pfx);
		in_valid <= 1'b1;
		opcode   <= op;
		prefixed <= pfx;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			// Junk on the payload while valid is low must be ignored.
			in_valid <= 1'b0;
			opcode   <= 8'($urandom);
			prefixed <= 1'($urandom);
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	initial begin
		int classes_covered;
		idle_pct   = 20;
		items_sent = 0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		opcode   <= '0;
		prefixed <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items: table edges, immediates, loads with fixed addressing,
		// and the holes that decode as errors (HALT, SBC immediate, LD r,d8,
		// BIT/SET above bit zero).
		send_opcode(8'h00, 1'b0);
		send_opcode(8'hFF, 1'b0);
		send_opcode(8'h76, 1'b0);
		send_opcode(8'h06, 1'b0);
		send_opcode(8'hDE, 1'b0);
		send_opcode(8'h36, 1'b0);
		send_opcode(8'h3E, 1'b0);
		send_opcode(8'hC6, 1'b0);
		send_opcode(8'hE9, 1'b0);
		send_opcode(8'hF8, 1'b0);
		send_opcode(8'h08, 1'b0);
		send_opcode(8'hF9, 1'b0);
		send_opcode(8'hE0, 1'b0);
		send_opcode(8'hF0, 1'b0);
		send_opcode(8'h20, 1'b0);
		send_opcode(8'h40, 1'b0);
		send_opcode(8'h80, 1'b0);
		send_opcode(8'h00, 1'b1);
		send_opcode(8'h3F, 1'b1);
		send_opcode(8'h47, 1'b1);
		send_opcode(8'h48, 1'b1);
		send_opcode(8'h87, 1'b1);
		send_opcode(8'hC7, 1'b1);
		send_opcode(8'hFF, 1'b1);

		// Every opcode in both tables is equally likely; the idle rate changes
		// by segment, including segments with no idling at all.
		for (int i = 0; i < RandomItems; i++) begin
			if (i >= RandomItems - CalmTail)
				idle_pct = 0;
			else if (i % SegmentLen == 0) begin
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 10;
					2: idle_pct = 30;
					default: idle_pct = 60;
				endcase
			end
			send_opcode(8'($urandom), 1'($urandom));
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (TailCycles) @(posedge clk);

		classes_covered = $countones(class_hits);
		$display("Sent %0d opcodes (plain and prefixed), checked %0d decodes.",
			items_sent, results_checked);
		$display("Decodes covered %0d of 37 instruction classes; %0d mismatches.",
			classes_covered, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("** cpu_opcode_decoder: PASSED **");
		else
			$display("** cpu_opcode_decoder: FAILED **");
		$finish;
	end

endmodule
